// ===== design/tqp_pkg.sv =====
// tone queue player package: payload structs, controller states, command codes
// and the control/status structs between controller and datapath
// no dependencies
`timescale 1ns / 1ps

package tqp_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam logic BEEP_ON_RST = 1'b1;  // beeping enabled out of reset

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  typedef struct packed {
    logic        command;
    logic [15:0] pitch;
    logic [15:0] duration;
  } in_item_t;

  typedef struct packed {
    logic [15:0] period;
    logic [14:0] compare;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_POP
  } state_t;

  typedef struct packed {
    logic enq_we;   // store the accepted note if beeping is enabled
    logic cnt_dec;  // decrement the countdown
    logic pop;      // take the next note and load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/tqp_ctrl.sv =====
// tone queue player controller: accepts transactions and sequences the
// note pop through the queue memory read; uses tqp_pkg
`timescale 1ns / 1ps

module tqp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_command,
  output logic               in_ready,
  input  tqp_pkg::dp_status_t status,
  output tqp_pkg::ctrl_cmd_t  cmd
);

  tqp_pkg::state_t state_r, state_nxt;
  logic accept;

  assign accept = in_valid && (state_r == tqp_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tqp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tqp_pkg::ST_IDLE: begin
        if (accept && in_command == tqp_pkg::CMD_TICK && status.cnt_zero) begin
          state_nxt = tqp_pkg::ST_READ;
        end
      end
      tqp_pkg::ST_READ: begin
        state_nxt = tqp_pkg::ST_POP;
      end
      tqp_pkg::ST_POP: begin
        // hold until the result register can take the note
        if (status.out_free) begin
          state_nxt = tqp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tqp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = (state_r == tqp_pkg::ST_IDLE);
    cmd.enq_we  = accept && (in_command == tqp_pkg::CMD_ENQUEUE);
    cmd.cnt_dec = accept && (in_command == tqp_pkg::CMD_TICK) && !status.cnt_zero;
    cmd.pop     = (state_r == tqp_pkg::ST_POP) && status.out_free;
  end

endmodule

// ===== design/tqp_datapath.sv =====
// tone queue player datapath: note ring memory, pointers, countdown,
// beep enable register and result register; uses tqp_pkg
`timescale 1ns / 1ps

module tqp_datapath #(
  parameter int QUEUE_DEPTH = tqp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  tqp_pkg::in_item_t   in_data,
  input  tqp_pkg::ctrl_cmd_t  cmd,
  output tqp_pkg::dp_status_t status,
  output logic                out_valid,
  input  logic                out_ready,
  output tqp_pkg::out_item_t  out_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [31:0]      mem [QUEUE_DEPTH];  // {pitch, duration}
  logic [31:0]      rd_data_r;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [15:0]      cnt_r, cnt_nxt;
  logic             beep_en_r;
  logic             out_valid_r;
  tqp_pkg::out_item_t out_data_r;

  logic             do_write;
  logic             empty;
  logic [15:0]      pop_period;
  logic [15:0]      pop_length;

  assign do_write = cmd.enq_we && beep_en_r;
  assign empty    = (rd_ptr_r == wr_ptr_r);

  // the ring has no full check: a write that catches the read pointer empties it
  assign wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;

  assign pop_period = empty ? 16'd0 : rd_data_r[31:16];
  assign pop_length = empty ? 16'd0 : rd_data_r[15:0];

  always_comb begin
    cnt_nxt = cnt_r;
    priority if (cmd.pop) begin
      cnt_nxt = pop_length;
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_ptr_r] <= {in_data.pitch, in_data.duration};
    end
    rd_data_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      beep_en_r   <= tqp_pkg::BEEP_ON_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        beep_en_r <= cfg_wdata;
      end
      if (do_write) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (cmd.pop && !empty) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      cnt_r <= cnt_nxt;
      if (cmd.pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_data_r.period  <= pop_period;
      out_data_r.compare <= pop_period[15:1];
    end
  end

  always_comb begin
    status.cnt_zero = (cnt_r == 16'd0);
    status.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/tone_queue_player.sv =====
// tone queue player top level: buzzer note sequencer
// instantiates tqp_ctrl and tqp_datapath; uses tqp_pkg
`timescale 1ns / 1ps

// Buzzer note sequencer. An enqueue transaction stores a note (PWM period and
// duration in ticks) in a QUEUE_DEPTH-entry ring while beeping is enabled; the
// ring has no full check, so an overrun empties it. A tick transaction counts
// the countdown down, and when it is already zero pops the next note (or
// period 0 if the queue is empty) and emits the new period and compare =
// period/2; a note lasts duration+1 ticks. Enqueues and ticks that only count
// down are taken in ST_IDLE. A tick that pops is accepted in ST_IDLE, reads the
// note memory through its registered read in ST_READ and loads the result
// register in ST_POP once a previous result is taken, accepting nothing else
// meanwhile. The result register lets a new transaction be accepted while a result waits.
module tone_queue_player #(
  parameter int QUEUE_DEPTH = tqp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  tqp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tqp_pkg::out_item_t out_data
);

  tqp_pkg::ctrl_cmd_t  cmd;
  tqp_pkg::dp_status_t status;

  tqp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_ready   (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  tqp_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== bench/tb_tone_queue_player.sv =====
// testbench for tone_queue_player: directed stimulus table, then random note and tick
// traffic under varying idling, checked against a note queue predictor
// depends on tqp_pkg and tone_queue_player
`timescale 1ns / 1ps

module tb_tone_queue_player;

  localparam int DEPTH         = tqp_pkg::QUEUE_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int BLOCK_ITEMS   = 148;

  typedef struct {
    bit                 is_cfg;
    bit                 cfg_val;
    tqp_pkg::in_item_t  item;
    bit                 typed;
    tqp_pkg::out_item_t want;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  tqp_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  tqp_pkg::out_item_t out_data;

  // predictor state
  logic [15:0] note_pitch [DEPTH];
  logic [15:0] note_len [DEPTH];
  int          wr_ptr;
  int          rd_ptr;
  logic [15:0] ticks_left;
  bit          beep_on;

  tqp_pkg::out_item_t tone_q [$];
  row_t               dir_rows [$];
  bit                 row_typed;
  tqp_pkg::out_item_t row_want;
  bit                 in_took;
  bit                 out_took;
  int                 errors;
  int                 stall_cycles;
  int                 tx_idle_pct;
  int                 rx_idle_pct;
  int                 run_phase;
  int                 hold_left;
  bit                 hold_done;

  tone_queue_player DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // advances the note queue by one transaction, returns 1 when a new tone is emitted
  function automatic bit next_tone(input tqp_pkg::in_item_t it,
                                   output tqp_pkg::out_item_t tone);
    logic [15:0] per;
    logic [15:0] len;
    tone = '0;
    if (it.command == tqp_pkg::CMD_ENQUEUE) begin
      if (beep_on) begin
        note_pitch[wr_ptr] = it.pitch;
        note_len[wr_ptr] = it.duration;
        wr_ptr = (wr_ptr + 1) % DEPTH;
      end
      return 1'b0;
    end
    if (ticks_left != 16'd0) begin
      ticks_left = ticks_left - 16'd1;
      return 1'b0;
    end
    if (rd_ptr == wr_ptr) begin
      per = 16'd0;
      len = 16'd0;
    end else begin
      per = note_pitch[rd_ptr];
      len = note_len[rd_ptr];
      rd_ptr = (rd_ptr + 1) % DEPTH;
    end
    ticks_left = len;
    tone.period = per;
    tone.compare = per[15:1];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin : monitor
    tqp_pkg::out_item_t tone;
    tqp_pkg::out_item_t want;
    bit                 made;
    in_took = rst_n && in_valid && in_ready;
    out_took = rst_n && out_valid && out_ready;
    if (rst_n) begin
      if (cfg_we) beep_on = cfg_wdata;
      if (in_took) begin
        made = next_tone(in_data, tone);
        if (row_typed) tone_q.push_back(row_want);
        else if (made) tone_q.push_back(tone);
      end
      if (out_took) begin
        if (tone_q.size() == 0) begin
          report_mismatch("unexpected result, period", out_data.period, 16'd0);
        end else begin
          want = tone_q.pop_front();
          if (out_data.period !== want.period)
            report_mismatch("period", out_data.period, want.period);
          if (out_data.compare !== want.compare)
            report_mismatch("compare", {1'b0, out_data.compare}, {1'b0, want.compare});
        end
      end
      if (in_took || out_took || cfg_we) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_tone_queue_player failed");
        $finish;
      end
    end
  end

  // receiver: random back-pressure, plus one long hold-off when the no-idle phase starts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (run_phase == 2 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready = 1'b0;
      end else begin
        out_ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_item(input tqp_pkg::in_item_t it, input bit typed,
                           input tqp_pkg::out_item_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    row_typed = typed;
    row_want = want;
    @(negedge clk);
    while (!in_took) @(negedge clk);
  endtask

  // waits until no tone is outstanding and the pipeline has drained, then writes the register
  task automatic write_beep(input bit val);
    in_valid = 1'b0;
    row_typed = 1'b0;
    while (tone_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic row_t note(input logic [15:0] p, input logic [15:0] d);
    row_t r;
    r = '{is_cfg: 1'b0, cfg_val: 1'b0, item: '{tqp_pkg::CMD_ENQUEUE, p, d}, typed: 1'b0,
          want: '0};
    return r;
  endfunction

  function automatic row_t tick(input logic [15:0] p, input logic [15:0] d);
    row_t r;
    r = '{is_cfg: 1'b0, cfg_val: 1'b0, item: '{tqp_pkg::CMD_TICK, p, d}, typed: 1'b0,
          want: '0};
    return r;
  endfunction

  function automatic row_t tick_want(input logic [15:0] p, input logic [15:0] d,
                                     input logic [15:0] per, input logic [14:0] cmp);
    row_t r;
    r = '{is_cfg: 1'b0, cfg_val: 1'b0, item: '{tqp_pkg::CMD_TICK, p, d}, typed: 1'b1,
          want: '{per, cmp}};
    return r;
  endfunction

  function automatic row_t set_beep(input bit v);
    row_t r;
    r = '{is_cfg: 1'b1, cfg_val: v, item: '0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic tqp_pkg::in_item_t random_item();
    tqp_pkg::in_item_t it;
    it.command = ($urandom_range(99) < 45) ? tqp_pkg::CMD_ENQUEUE : tqp_pkg::CMD_TICK;
    it.pitch = 16'($urandom);
    it.duration = ($urandom_range(99) < 85) ? 16'($urandom_range(3))
                                            : 16'($urandom_range(20));
    return it;
  endfunction

  initial begin
    clk_setup: begin
      rst_n = 1'b0;
      cfg_we = 1'b0;
      cfg_wdata = 1'b0;
      in_valid = 1'b0;
      in_data = '0;
      row_typed = 1'b0;
      row_want = '0;
      errors = 0;
      stall_cycles = 0;
      tx_idle_pct = 0;
      rx_idle_pct = 30;
      run_phase = -1;
      hold_left = 0;
      hold_done = 1'b0;
      wr_ptr = 0;
      rd_ptr = 0;
      ticks_left = 16'd0;
      beep_on = tqp_pkg::BEEP_ON_RST;
      for (int i = 0; i < DEPTH; i++) begin
        note_pitch[i] = 16'd0;
        note_len[i] = 16'd0;
      end
    end

    // empty queue after reset gives silence
    dir_rows.push_back(tick_want(16'h0000, 16'h0000, 16'h0000, 15'h0000));
    dir_rows.push_back(note(16'hFFFF, 16'h0000));
    dir_rows.push_back(note(16'h0001, 16'h0001));
    dir_rows.push_back(tick_want(16'h0000, 16'h0000, 16'hFFFF, 15'h7FFF));
    // pitch and duration on a tick are don't-care
    dir_rows.push_back(tick_want(16'hFFFF, 16'hFFFF, 16'h0001, 15'h0000));
    dir_rows.push_back(tick(16'h0000, 16'h0000));
    dir_rows.push_back(tick(16'h0000, 16'h0000));
    // four writes wrap the ring onto the read pointer: queue looks empty, long notes lost
    dir_rows.push_back(note(16'hAAAA, 16'hFFFF));
    dir_rows.push_back(note(16'h5555, 16'h8000));
    dir_rows.push_back(note(16'h8000, 16'h7FFF));
    dir_rows.push_back(note(16'h7FFF, 16'h5555));
    dir_rows.push_back(tick_want(16'h0000, 16'h0000, 16'h0000, 15'h0000));
    dir_rows.push_back(note(16'h1234, 16'h0002));
    dir_rows.push_back(tick(16'h0000, 16'h0000));
    // notes are dropped while beeping is off
    dir_rows.push_back(set_beep(1'b0));
    dir_rows.push_back(note(16'hFFFF, 16'hFFFF));
    dir_rows.push_back(tick(16'h0000, 16'h0000));
    dir_rows.push_back(tick(16'h0000, 16'h0000));
    dir_rows.push_back(tick_want(16'h1234, 16'hAAAA, 16'h0000, 15'h0000));
    dir_rows.push_back(set_beep(1'b1));
    dir_rows.push_back(note(16'h0000, 16'h0000));
    dir_rows.push_back(tick(16'h0000, 16'h0000));
    dir_rows.push_back(note(16'h0002, 16'h0000));
    dir_rows.push_back(note(16'h0003, 16'h0000));
    dir_rows.push_back(tick(16'h0000, 16'h0000));

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_beep(dir_rows[i].cfg_val);
      else send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      for (int blk = 0; blk < 3; blk++) begin
        write_beep(blk != 1);
        if (blk == 0) begin
          tx_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 60 : 0;
          rx_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 21 : 0;
          run_phase = ph;
        end
        for (int n = 0; n < BLOCK_ITEMS; n++) send_item(random_item(), 1'b0, '0);
      end
    end

    in_valid = 1'b0;
    row_typed = 1'b0;
    while (tone_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES + 2) @(negedge clk);
    if (errors == 0 && tone_q.size() == 0) begin
      $display("tb_tone_queue_player passed");
    end else begin
      $display("tb_tone_queue_player failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tqp_pkg.sv
design/tqp_ctrl.sv
design/tqp_datapath.sv
design/tone_queue_player.sv
bench/tb_tone_queue_player.sv
